// ----- src/uartrx_pkg.sv -----
// Shared types and constants of the 8N1 UART receiver with receive FIFO.
// Used by the frame receiver, the FIFO and the top level; no dependencies.
package uartrx_pkg;

   localparam int DATA_BITS          = 8;
   localparam int BIT_TIME_W         = 16;
   localparam int COUNT_W            = BIT_TIME_W + 1;
   localparam int BITS_LEFT_W        = 4;
   localparam int BIT_INDEX_W        = 4;
   localparam int FIFO_DEPTH_DEFAULT = 16;
   localparam int REQ_DATA_W         = 8;
   localparam int RSP_DATA_W         = 16;

   localparam logic [BIT_TIME_W-1:0]  BIT_TIME_RESET = 16'd104;
   localparam logic [BITS_LEFT_W-1:0] FRAME_EVENTS   = 4'd10;
   localparam logic [BIT_INDEX_W-1:0] BIT_INDEX_END  = 4'd8;

   typedef struct packed {
      logic                 push;
      logic [DATA_BITS-1:0] data;
   } push_type;

   typedef struct packed {
      logic stored;
      logic receiving;
   } frame_status_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] head_byte;
      logic                 available;
      logic                 overflow;
   } fifo_status_type;

endpackage

// ----- src/uart_rx_8n1_with_fifo.sv -----
// Top level of the 8N1 UART receiver with receive FIFO: beat registers and CSR.
// Depends on uartrx_pkg, uartrx_frame and uartrx_fifo.
//
//   Channel  Direction  Payload
//   req_     in         tdata[0] rx_line, tdata[1] read_pop
//   rsp_     out        tdata[7:0] head_byte, [8] data_available, [9] byte_stored,
//                       [10] overflow, [11] receiving
//   csr_     in         data[15:0] bit_time
//
// One beat per clock is sustained while rsp_tready stays high. A request passes
// the input register, then the single pass through the frame counter and the FIFO
// pointer logic into the result register.
// Reset sets bit_time to 104 and empties the FIFO; no clearing pass is needed.
// A stalled result holds in the output register while one more request beat
// waits in the input register.
module uart_rx_8n1_with_fifo
   import uartrx_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // rx_line, read_pop, zero fill
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // head_byte, data_available,
                                             // byte_stored, overflow, receiving
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [BIT_TIME_W-1:0] csr_data
);

   logic                  in_valid_ff, in_valid_in;
   logic                  in_line_ff;
   logic                  in_pop_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [BIT_TIME_W-1:0] bit_time_ff;
   logic                  advance;
   logic                  req_accept;
   push_type              push_req;
   frame_status_type      frame_status;
   fifo_status_type       fifo_status;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         bit_time_ff  <= BIT_TIME_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            bit_time_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_line_ff <= req_tdata[0];
         in_pop_ff  <= req_tdata[1];
      end
   end

   uartrx_frame u_frame (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .line     (in_line_ff),
      .bit_time (bit_time_ff),
      .push_req (push_req),
      .status   (frame_status)
   );

   uartrx_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .pop      (in_pop_ff),
      .push_req (push_req),
      .status   (fifo_status)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        frame_status.receiving,
                        fifo_status.overflow,
                        frame_status.stored,
                        fifo_status.available,
                        fifo_status.head_byte};

endmodule

// ----- src/uartrx_frame.sv -----
// Frame receiver: start edge detection, bit-center countdown and data shift.
// Depends on uartrx_pkg.
module uartrx_frame
   import uartrx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  line,
   input  logic [BIT_TIME_W-1:0] bit_time,
   output push_type              push_req,
   output frame_status_type      status
);

   logic                   line_prev_ff, line_prev_in;
   logic [BITS_LEFT_W-1:0] bits_left_ff, bits_left_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [DATA_BITS-1:0]   shift_ff, shift_in;
   logic [BIT_INDEX_W-1:0] index_ff, index_in;
   logic                   stored_ff, stored_in;
   logic                   receiving_ff, receiving_in;

   always_comb begin
      line_prev_in = line;
      bits_left_in = bits_left_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      index_in     = index_ff;
      stored_in    = 1'b0;
      if (bits_left_ff == '0) begin
         if (line_prev_ff && !line) begin
            bits_left_in = FRAME_EVENTS;
            count_in     = {1'b0, bit_time} + {2'b00, bit_time[BIT_TIME_W-1:1]};
            shift_in     = '0;
            index_in     = '0;
         end
      end else if (count_ff > COUNT_W'(1)) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in     = {1'b0, bit_time};
         bits_left_in = bits_left_ff - 1'b1;
         if (bits_left_in > BITS_LEFT_W'(1)) begin
            if (index_ff < BIT_INDEX_END) begin
               shift_in[index_ff[2:0]] = shift_ff[index_ff[2:0]] | line;
               index_in                = index_ff + 1'b1;
            end
         end else begin
            stored_in    = 1'b1;
            bits_left_in = '0;
         end
      end
      receiving_in = (bits_left_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_prev_ff <= 1'b1;
         bits_left_ff <= '0;
         count_ff     <= '0;
         shift_ff     <= '0;
         index_ff     <= '0;
         stored_ff    <= 1'b0;
         receiving_ff <= 1'b0;
      end else if (step) begin
         line_prev_ff <= line_prev_in;
         bits_left_ff <= bits_left_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         index_ff     <= index_in;
         stored_ff    <= stored_in;
         receiving_ff <= receiving_in;
      end
   end

   assign push_req.push    = step && stored_in;
   assign push_req.data    = shift_ff;
   assign status.stored    = stored_ff;
   assign status.receiving = receiving_ff;

endmodule

// ----- src/uartrx_fifo.sv -----
// Receive ring FIFO with pop-before-push ordering and flush on overflow.
// Depends on uartrx_pkg; the byte store is a memory with a registered read.
module uartrx_fifo
   import uartrx_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic            pop,
   input  push_type        push_req,
   output fifo_status_type status
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   logic [DATA_BITS-1:0] mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_popped;
   logic [PTR_W-1:0]     wr_next;
   logic [PTR_W-1:0]     rd_next;
   logic [DATA_BITS-1:0] head_ff;
   logic                 head_valid_ff;
   logic                 available_ff;
   logic                 overflow_ff, overflow_in;
   logic                 empty;
   logic                 full;

   assign empty     = (rd_ptr_ff == wr_ptr_ff);
   assign rd_next   = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
   assign wr_next   = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_popped = (!empty && pop) ? rd_next : rd_ptr_ff;
   assign full      = (wr_next == rd_popped);

   always_comb begin
      rd_ptr_in   = rd_popped;
      wr_ptr_in   = wr_ptr_ff;
      overflow_in = 1'b0;
      if (push_req.push) begin
         wr_ptr_in = wr_next;
         if (full) begin
            rd_ptr_in   = wr_ptr_ff;
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_req.push) begin
         mem_ff[wr_ptr_ff] <= push_req.data;
      end
      if (step) begin
         head_ff <= mem_ff[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         head_valid_ff <= 1'b0;
         available_ff  <= 1'b0;
         overflow_ff   <= 1'b0;
      end else if (step) begin
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         head_valid_ff <= !empty;
         available_ff  <= (rd_ptr_in != wr_ptr_in);
         overflow_ff   <= overflow_in;
      end
   end

   assign status.head_byte = head_valid_ff ? head_ff : '0;
   assign status.available = available_ff;
   assign status.overflow  = overflow_ff;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for uart_rx_8n1_with_fifo: serial frames, FIFO pops and overflow.
// Builds on uartrx_pkg and the RTL under src; drives req_/csr_ beats and checks every rsp_ beat.
module tb_top
   import uartrx_pkg::*;
;

   typedef struct packed {
      logic pop;
      logic line;
   } line_tick_type;

   typedef struct packed {
      logic                 receiving;
      logic                 overflow;
      logic                 byte_stored;
      logic                 data_available;
      logic [DATA_BITS-1:0] head_byte;
   } rx_tick_result_type;

   localparam int RX_DEPTH = 16;
   localparam int PTR_W    = 4;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [BIT_TIME_W-1:0] csr_data   = '0;

   line_tick_type      line_ticks[$];
   rx_tick_result_type rx_results_due[$];
   int                 mismatch_count = 0;
   bit                 steady         = 1'b0;
   bit                 stall_phase    = 1'b0;
   bit                 hold_done      = 1'b0;
   int                 hold_left      = 0;

   logic [BIT_TIME_W-1:0]  baud_period;
   logic                   line_prev;
   logic [BITS_LEFT_W-1:0] events_left;
   logic [COUNT_W-1:0]     countdown;
   logic [DATA_BITS-1:0]   shift_byte;
   logic [BIT_INDEX_W-1:0] sample_index;
   logic [DATA_BITS-1:0]   rx_fifo[RX_DEPTH];
   logic [PTR_W-1:0]       wr_ptr;
   logic [PTR_W-1:0]       rd_ptr;

   uart_rx_8n1_with_fifo DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The pop is applied first, then the receiver advances by one tick.
   function automatic rx_tick_result_type step_receiver(input logic line, input logic pop);
      rx_tick_result_type r;
      r = '0;
      if (rd_ptr != wr_ptr) begin
         r.head_byte = rx_fifo[rd_ptr];
         if (pop) begin
            rd_ptr = PTR_W'(rd_ptr + 1);
         end
      end
      if (events_left == 0) begin
         if (line_prev && !line) begin
            events_left  = FRAME_EVENTS;
            countdown    = COUNT_W'(baud_period) + COUNT_W'(baud_period >> 1);
            shift_byte   = '0;
            sample_index = '0;
         end
      end else if (countdown > 1) begin
         countdown = countdown - 1'b1;
      end else begin
         countdown   = COUNT_W'(baud_period);
         events_left = events_left - 1'b1;
         if (events_left > 1) begin
            if (sample_index < BIT_INDEX_END) begin
               shift_byte[sample_index] = line;
               sample_index = sample_index + 1'b1;
            end
         end else begin
            if (PTR_W'(wr_ptr + 1) == rd_ptr) begin
               rd_ptr     = wr_ptr;
               r.overflow = 1'b1;
            end
            rx_fifo[wr_ptr] = shift_byte;
            wr_ptr          = PTR_W'(wr_ptr + 1);
            r.byte_stored   = 1'b1;
            events_left     = '0;
         end
      end
      line_prev        = line;
      r.data_available = (rd_ptr != wr_ptr);
      r.receiving      = (events_left != 0);
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      line_tick_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (line_ticks.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
            item = line_ticks.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_DATA_W'({item.pop, item.line});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_phase && !hold_done && rsp_tvalid) begin
         hold_left  <= 80;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || $urandom_range(99) >= 28;
      end
   end

   always @(posedge clock) begin
      rx_tick_result_type due;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            rx_results_due.push_back(step_receiver(req_tdata[0], req_tdata[1]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (rx_results_due.size() == 0) begin
               flag_mismatch("result beat with nothing due", rsp_tdata, 0);
            end else begin
               due = rx_results_due.pop_front();
               if (rsp_tdata[7:0] != due.head_byte)
                  flag_mismatch("head_byte", rsp_tdata[7:0], due.head_byte);
               if (rsp_tdata[8] != due.data_available)
                  flag_mismatch("data_available", rsp_tdata[8], due.data_available);
               if (rsp_tdata[9] != due.byte_stored)
                  flag_mismatch("byte_stored", rsp_tdata[9], due.byte_stored);
               if (rsp_tdata[10] != due.overflow)
                  flag_mismatch("overflow", rsp_tdata[10], due.overflow);
               if (rsp_tdata[11] != due.receiving)
                  flag_mismatch("receiving", rsp_tdata[11], due.receiving);
            end
         end
      end
   end

   task automatic write_bit_time(input logic [BIT_TIME_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      baud_period = value;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (line_ticks.size() != 0 || rx_results_due.size() != 0 || req_tvalid || rsp_tvalid);
      repeat (4) @(negedge clock);
   endtask

   task automatic queue_tick(input logic line, input int pop_pct);
      line_tick_type t;
      t.line = line;
      t.pop  = ($urandom_range(99) < pop_pct);
      line_ticks.push_back(t);
   endtask

   task automatic queue_frame(input logic [7:0] value, input int period, input int pop_pct,
                              input logic stop_level);
      logic [9:0] levels;
      levels = {stop_level, value, 1'b0};
      for (int i = 0; i < 10; i++) begin
         for (int k = 0; k < period; k++) begin
            queue_tick(levels[i], pop_pct);
         end
      end
   endtask

   // Mostly well-formed frames with random bytes; some noise bursts and frames with a low stop bit.
   task automatic run_frames(input logic [BIT_TIME_W-1:0] period, input int frames,
                             input int pop_pct, input int noise_pct);
      int ticks_per_bit;
      ticks_per_bit = (period == 0) ? 1 : period;
      write_bit_time(period);
      for (int f = 0; f < frames; f++) begin
         if ($urandom_range(99) < noise_pct) begin
            if ($urandom_range(1)) begin
               repeat ($urandom_range(3, 12)) queue_tick(1'($urandom_range(1)), 40);
            end else begin
               queue_frame(8'($urandom_range(255)), ticks_per_bit, pop_pct, 1'b0);
            end
         end else begin
            queue_frame(8'($urandom_range(255)), ticks_per_bit, pop_pct, 1'b1);
         end
         repeat ($urandom_range(0, 2)) queue_tick(1'b1, pop_pct);
      end
      wait_idle();
   endtask

   initial begin
      baud_period  = BIT_TIME_RESET;
      line_prev    = 1'b1;
      events_left  = '0;
      countdown    = '0;
      shift_byte   = '0;
      sample_index = '0;
      wr_ptr       = '0;
      rd_ptr       = '0;
      foreach (rx_fifo[i]) rx_fifo[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_bit_time(16'd1);
      queue_tick(1'b1, 100);
      queue_tick(1'b1, 100);
      queue_frame(8'hFF, 1, 0, 1'b1);
      queue_tick(1'b1, 0);
      queue_tick(1'b1, 100);
      queue_frame(8'h00, 1, 0, 1'b0);
      queue_tick(1'b1, 100);
      queue_tick(1'b1, 100);
      wait_idle();

      run_frames(16'd0, 3, 10, 0);
      stall_phase <= 1'b1;
      run_frames(16'd2, 6, 5, 10);
      run_frames(16'd1, 19, 0, 0);
      steady = 1'b1;
      run_frames(BIT_TIME_W'($urandom_range(3, 6)), 3, 8, 0);
      steady = 1'b0;
      run_frames(BIT_TIME_W'($urandom_range(1, 3)), 8, 30, 50);

      write_bit_time(16'hFFFF);
      repeat (3) queue_tick(1'b1, 50);
      repeat (35) queue_tick(1'($urandom_range(1)), 50);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("[uart_rx_8n1_with_fifo] OK");
      end else begin
         $display("[uart_rx_8n1_with_fifo] ERROR");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("[uart_rx_8n1_with_fifo] ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
src/uartrx_pkg.sv
src/uartrx_frame.sv
src/uartrx_fifo.sv
src/uart_rx_8n1_with_fifo.sv
dv/tb_top.sv
